// ----- hdl/lav_pkg.sv -----
// Shared types and constants for the look-at view matrix core.
package lav_pkg;

  localparam int FIELD_W = 32;
  localparam int AXES    = 3;
  localparam int FRAC_W  = 30;
  localparam int NORM_W  = 30;
  localparam int ROOT_W  = 31;
  localparam int QUOT_W  = 31;
  localparam int WIDE_W  = 64;
  localparam int DIR_W   = FIELD_W + 1;
  localparam int QRND_W  = WIDE_W - FRAC_W;

  localparam logic [FIELD_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [FIELD_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic signed [FIELD_W-1:0] eye_x;
    logic signed [FIELD_W-1:0] eye_y;
    logic signed [FIELD_W-1:0] eye_z;
    logic signed [FIELD_W-1:0] target_x;
    logic signed [FIELD_W-1:0] target_y;
    logic signed [FIELD_W-1:0] target_z;
    logic signed [FIELD_W-1:0] up_x;
    logic signed [FIELD_W-1:0] up_y;
    logic signed [FIELD_W-1:0] up_z;
  } in_word_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] right_x;
    logic signed [FIELD_W-1:0] right_y;
    logic signed [FIELD_W-1:0] right_z;
    logic signed [FIELD_W-1:0] right_shift;
    logic signed [FIELD_W-1:0] upward_x;
    logic signed [FIELD_W-1:0] upward_y;
    logic signed [FIELD_W-1:0] upward_z;
    logic signed [FIELD_W-1:0] upward_shift;
    logic signed [FIELD_W-1:0] forward_x;
    logic signed [FIELD_W-1:0] forward_y;
    logic signed [FIELD_W-1:0] forward_z;
    logic signed [FIELD_W-1:0] forward_shift;
  } out_word_t;

endpackage

// ----- hdl/look_at_view_matrix_core.sv -----
// Top level of the left-handed look-at view matrix core.
// Throughput: one word per cycle while the skid entry is free; the two square root and division pipelines
// each retire one result bit per stage, which sets the depth.
// A two-entry output buffer lets the pipeline keep running while a result waits.
// Reset (rst, synchronous, active high) empties every stage; no clearing pass.
module look_at_view_matrix_core #(
  parameter int COORD_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lav_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lav_pkg::out_word_t out_data
);
  import lav_pkg::*;

  // Only the low bits of each coordinate count, sign-extended from that width.
  localparam int CW   = (COORD_WIDTH >= FIELD_W) ? FIELD_W : COORD_WIDTH;
  localparam int SX_W = FIELD_W - CW;
  localparam int U1_SIDE_W = 2 * AXES * FIELD_W;
  localparam int U2_SIDE_W = 2 * AXES * FIELD_W + 1;

  // Everything that rides along behind the second normalization.
  typedef struct packed {
    logic [AXES-1:0][FIELD_W-1:0] eye;
    logic [AXES-1:0][FIELD_W-1:0] fw;
    logic [AXES-1:0][FIELD_W-1:0] rt;
    logic [AXES-1:0][FIELD_W-1:0] uw;
    logic                         zero;
  } carry_t;

  function automatic logic signed [FIELD_W-1:0] take_coord(input logic [FIELD_W-1:0] raw);
    logic [FIELD_W-1:0] up_shift;
    up_shift = raw << SX_W;
    return $signed(up_shift) >>> SX_W;
  endfunction

  // The pipeline advances whenever the skid entry is free.
  logic en;
  logic skid_vld;
  out_word_t skid_data;
  assign en       = ~skid_vld;
  assign in_ready = en;

  // Input stage: sign extension and view direction.
  logic v0;
  logic [AXES-1:0][FIELD_W-1:0] eye0, up0;
  logic [AXES-1:0][DIR_W-1:0]   dir0;
  logic signed [FIELD_W-1:0] eye_c [AXES];
  logic signed [FIELD_W-1:0] tgt_c [AXES];
  logic signed [FIELD_W-1:0] up_c  [AXES];

  always_comb begin
    eye_c[0] = take_coord(in_data.eye_x);
    eye_c[1] = take_coord(in_data.eye_y);
    eye_c[2] = take_coord(in_data.eye_z);
    tgt_c[0] = take_coord(in_data.target_x);
    tgt_c[1] = take_coord(in_data.target_y);
    tgt_c[2] = take_coord(in_data.target_z);
    up_c[0]  = take_coord(in_data.up_x);
    up_c[1]  = take_coord(in_data.up_y);
    up_c[2]  = take_coord(in_data.up_z);
  end

  // Forward axis.
  logic v_u1, zero_u1;
  logic [AXES-1:0][FIELD_W-1:0] fw_u1, eye_u1, up_u1;

  // Right axis: cross(up, forward) products, then differences.
  logic v1, v2;
  logic signed [WIDE_W-1:0] cp1 [AXES];
  logic signed [WIDE_W-1:0] cn1 [AXES];
  logic [AXES-1:0][FIELD_W-1:0] eye1, fw1, eye2, fw2;
  logic zero1, zero2;
  logic [AXES-1:0][WIDE_W-1:0] rc2;

  logic v_u2, zero_u2, zero_f;
  logic [AXES-1:0][FIELD_W-1:0] rt_u2, eye_u2, fw_u2;

  // Upward axis, translations and the final result.
  logic [12:3] vs;
  carry_t c3, c4, c5, c6, c7, c8, c9, c10, c11;
  logic signed [WIDE_W-1:0] yp3 [AXES];
  logic signed [WIDE_W-1:0] yn3 [AXES];
  logic signed [WIDE_W-1:0] yc4 [AXES];
  logic [WIDE_W-1:0] ym5 [AXES];
  logic [AXES-1:0] yneg5, yneg6, dneg10, dneg11;
  logic [QRND_W-1:0] yq6 [AXES];
  logic [WIDE_W-1:0] yr_c [AXES];
  logic signed [WIDE_W-1:0] dp8 [AXES][AXES];
  logic signed [WIDE_W-1:0] d9 [AXES];
  logic [WIDE_W-1:0] dm10 [AXES];
  logic [WIDE_W-1:0] dr_c [AXES];
  logic [QRND_W-1:0] dq11 [AXES];
  logic [AXES-1:0][FIELD_W-1:0] ax_c, sh_c;
  out_word_t p_data;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      yr_c[i] = ym5[i] + (WIDE_W'(1) << (FRAC_W - 1));
      dr_c[i] = dm10[i] + (WIDE_W'(1) << (FRAC_W - 1));
    end
  end

  // Rows in order right, upward, forward.
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      ax_c[i] = '0;
    end
    for (int i = 0; i < AXES; i++) begin
      // The translation is the negated dot product, saturated to 32 bits.
      if (dneg11[i]) begin
        sh_c[i] = (dq11[i] > QRND_W'(SAT_MAX)) ? SAT_MAX : dq11[i][FIELD_W-1:0];
      end else begin
        sh_c[i] = (dq11[i] > QRND_W'(SAT_MIN)) ? SAT_MIN
                                               : FIELD_W'(0) - dq11[i][FIELD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      vs <= '0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v_u1;
      v2 <= v1;
      vs <= {vs[11:3], v_u2};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < AXES; i++) begin
        eye0[i] <= eye_c[i];
        up0[i]  <= up_c[i];
        dir0[i] <= DIR_W'(tgt_c[i]) - DIR_W'(eye_c[i]);
      end

      for (int i = 0; i < AXES; i++) begin
        cp1[i] <= $signed(up_u1[(i + 1) % AXES]) * $signed(fw_u1[(i + 2) % AXES]);
        cn1[i] <= $signed(up_u1[(i + 2) % AXES]) * $signed(fw_u1[(i + 1) % AXES]);
      end
      eye1  <= eye_u1;
      fw1   <= fw_u1;
      zero1 <= zero_u1;

      for (int i = 0; i < AXES; i++) rc2[i] <= cp1[i] - cn1[i];
      eye2  <= eye1;
      fw2   <= fw1;
      zero2 <= zero1;

      // Upward axis is cross(forward, right), rounded back to Q2.30.
      for (int i = 0; i < AXES; i++) begin
        yp3[i] <= $signed(fw_u2[(i + 1) % AXES]) * $signed(rt_u2[(i + 2) % AXES]);
        yn3[i] <= $signed(fw_u2[(i + 2) % AXES]) * $signed(rt_u2[(i + 1) % AXES]);
      end
      c3.eye  <= eye_u2;
      c3.fw   <= fw_u2;
      c3.rt   <= rt_u2;
      c3.uw   <= '0;
      c3.zero <= zero_u2 | zero_f;

      for (int i = 0; i < AXES; i++) yc4[i] <= yp3[i] - yn3[i];
      c4 <= c3;

      for (int i = 0; i < AXES; i++) begin
        yneg5[i] <= yc4[i][WIDE_W-1];
        ym5[i]   <= yc4[i][WIDE_W-1] ? (WIDE_W'(0) - yc4[i]) : yc4[i];
      end
      c5 <= c4;

      for (int i = 0; i < AXES; i++) yq6[i] <= yr_c[i][WIDE_W-1:FRAC_W];
      yneg6 <= yneg5;
      c6    <= c5;

      c7.eye  <= c6.eye;
      c7.fw   <= c6.fw;
      c7.rt   <= c6.rt;
      c7.zero <= c6.zero;
      for (int i = 0; i < AXES; i++) begin
        c7.uw[i] <= yneg6[i] ? FIELD_W'(0) - yq6[i][FIELD_W-1:0] : yq6[i][FIELD_W-1:0];
      end

      for (int i = 0; i < AXES; i++) begin
        dp8[0][i] <= $signed(c7.eye[i]) * $signed(c7.rt[i]);
        dp8[1][i] <= $signed(c7.eye[i]) * $signed(c7.uw[i]);
        dp8[2][i] <= $signed(c7.eye[i]) * $signed(c7.fw[i]);
      end
      c8 <= c7;

      for (int a = 0; a < AXES; a++) d9[a] <= dp8[a][0] + dp8[a][1] + dp8[a][2];
      c9 <= c8;

      for (int a = 0; a < AXES; a++) begin
        dneg10[a] <= d9[a][WIDE_W-1];
        dm10[a]   <= d9[a][WIDE_W-1] ? (WIDE_W'(0) - d9[a]) : d9[a];
      end
      c10 <= c9;

      for (int a = 0; a < AXES; a++) dq11[a] <= dr_c[a][WIDE_W-1:FRAC_W];
      dneg11 <= dneg10;
      c11    <= c10;

      if (c11.zero) begin
        p_data <= '0;
      end else begin
        p_data.right_x       <= c11.rt[0];
        p_data.right_y       <= c11.rt[1];
        p_data.right_z       <= c11.rt[2];
        p_data.right_shift   <= sh_c[0] | ax_c[0];
        p_data.upward_x      <= c11.uw[0];
        p_data.upward_y      <= c11.uw[1];
        p_data.upward_z      <= c11.uw[2];
        p_data.upward_shift  <= sh_c[1] | ax_c[1];
        p_data.forward_x     <= c11.fw[0];
        p_data.forward_y     <= c11.fw[1];
        p_data.forward_z     <= c11.fw[2];
        p_data.forward_shift <= sh_c[2] | ax_c[2];
      end
    end
  end

  lav_unit #(.IN_W(DIR_W), .SIDE_W(U1_SIDE_W)) u_forward (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v0),
    .vec       (dir0),
    .in_side   ({eye0, up0}),
    .out_valid (v_u1),
    .axis      (fw_u1),
    .zero      (zero_u1),
    .out_side  ({eye_u1, up_u1})
  );

  lav_unit #(.IN_W(WIDE_W), .SIDE_W(U2_SIDE_W)) u_right (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .vec       (rc2),
    .in_side   ({eye2, fw2, zero2}),
    .out_valid (v_u2),
    .axis      (rt_u2),
    .zero      (zero_u2),
    .out_side  ({eye_u2, fw_u2, zero_f})
  );

  // Output register with one skid entry behind it. A word leaves the last
  // stage only on an edge where the pipeline advances.
  logic take;
  assign take = en & vs[12];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_vld  <= 1'b0;
    end else if (skid_vld) begin
      if (out_ready) begin
        out_valid <= 1'b1;
        skid_vld  <= 1'b0;
      end
    end else if (~out_valid | out_ready) begin
      out_valid <= take;
    end else if (take) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld) begin
      if (out_ready) out_data <= skid_data;
    end else if (~out_valid | out_ready) begin
      if (take) out_data <= p_data;
    end else if (take) begin
      skid_data <= p_data;
    end
  end

  // The skid entry is only ever filled behind a stalled output word.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_vld |-> out_valid)
    else $error("skid entry holds a word while the output register is empty");

  a_skid_fill_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_vld) |-> $past(out_valid && !out_ready && vs[12]))
    else $error("skid entry filled without a stalled output and a finished word");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (skid_vld && out_ready) |=> (!skid_vld && out_valid))
    else $error("skid entry did not move into the output register");

  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    (skid_vld && !out_ready) |=> (skid_vld && $stable(skid_data)))
    else $error("skid entry changed while the output was stalled");

endmodule

// ----- hdl/lav_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module lav_sqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [lav_pkg::WIDE_W-1:0]  n,
  input  logic [SIDE_W-1:0]           in_side,
  output logic                        out_valid,
  output logic [lav_pkg::ROOT_W-1:0]  root,
  output logic [SIDE_W-1:0]           out_side
);
  import lav_pkg::*;

  logic [WIDE_W-1:0] rem_d  [ROOT_W];
  logic [WIDE_W-1:0] rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_d [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [SIDE_W-1:0] side_d [ROOT_W];
  logic [SIDE_W-1:0] side_q [ROOT_W];
  logic              vld_d  [ROOT_W];
  logic              vld_q  [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_step
    localparam int K = ROOT_W - 1 - s;
    logic [WIDE_W-1:0] trial;

    if (s == 0) begin : g_head
      assign rem_d[s]  = n;
      assign root_d[s] = '0;
      assign side_d[s] = in_side;
      assign vld_d[s]  = in_valid;
    end else begin : g_link
      assign rem_d[s]  = rem_q[s-1];
      assign root_d[s] = root_q[s-1];
      assign side_d[s] = side_q[s-1];
      assign vld_d[s]  = vld_q[s-1];
    end

    // (root + 2^K)^2 - root^2 = root * 2^(K+1) + 2^(2K).
    assign trial = (WIDE_W'(root_d[s]) << (K + 1)) + (WIDE_W'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else if (en) begin
        vld_q[s] <= vld_d[s];
      end
      if (en) begin
        side_q[s] <= side_d[s];
        if (rem_d[s] >= trial) begin
          rem_q[s]  <= rem_d[s] - trial;
          root_q[s] <= root_d[s] | (ROOT_W'(1) << K);
        end else begin
          rem_q[s]  <= rem_d[s];
          root_q[s] <= root_d[s];
        end
      end
    end
  end

  assign out_valid = vld_q[ROOT_W-1];
  assign root      = root_q[ROOT_W-1];
  assign out_side  = side_q[ROOT_W-1];

endmodule

// ----- hdl/lav_div.sv -----
// Pipelined restoring divider for three lanes sharing one divisor.
module lav_div #(
  parameter int SIDE_W = 1
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             en,
  input  logic                                             in_valid,
  input  logic [lav_pkg::AXES-1:0][lav_pkg::WIDE_W-1:0]    num,
  input  logic [lav_pkg::ROOT_W-1:0]                       den,
  input  logic [SIDE_W-1:0]                                in_side,
  output logic                                             out_valid,
  output logic [lav_pkg::AXES-1:0][lav_pkg::QUOT_W-1:0]    quot,
  output logic [SIDE_W-1:0]                                out_side
);
  import lav_pkg::*;

  logic [AXES-1:0][WIDE_W-1:0] rem_d  [QUOT_W];
  logic [AXES-1:0][WIDE_W-1:0] rem_q  [QUOT_W];
  logic [AXES-1:0][QUOT_W-1:0] quot_d [QUOT_W];
  logic [AXES-1:0][QUOT_W-1:0] quot_q [QUOT_W];
  logic [ROOT_W-1:0]           den_d  [QUOT_W];
  logic [ROOT_W-1:0]           den_q  [QUOT_W];
  logic [SIDE_W-1:0]           side_d [QUOT_W];
  logic [SIDE_W-1:0]           side_q [QUOT_W];
  logic                        vld_d  [QUOT_W];
  logic                        vld_q  [QUOT_W];

  for (genvar s = 0; s < QUOT_W; s++) begin : g_step
    localparam int K = QUOT_W - 1 - s;
    logic [WIDE_W-1:0] sub;

    if (s == 0) begin : g_head
      assign rem_d[s]  = num;
      assign quot_d[s] = '0;
      assign den_d[s]  = den;
      assign side_d[s] = in_side;
      assign vld_d[s]  = in_valid;
    end else begin : g_link
      assign rem_d[s]  = rem_q[s-1];
      assign quot_d[s] = quot_q[s-1];
      assign den_d[s]  = den_q[s-1];
      assign side_d[s] = side_q[s-1];
      assign vld_d[s]  = vld_q[s-1];
    end

    assign sub = WIDE_W'(den_d[s]) << K;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else if (en) begin
        vld_q[s] <= vld_d[s];
      end
      if (en) begin
        side_q[s] <= side_d[s];
        den_q[s]  <= den_d[s];
        for (int a = 0; a < AXES; a++) begin
          if (rem_d[s][a] >= sub) begin
            rem_q[s][a]  <= rem_d[s][a] - sub;
            quot_q[s][a] <= quot_d[s][a] | (QUOT_W'(1) << K);
          end else begin
            rem_q[s][a]  <= rem_d[s][a];
            quot_q[s][a] <= quot_d[s][a];
          end
        end
      end
    end
  end

  assign out_valid = vld_q[QUOT_W-1];
  assign quot      = quot_q[QUOT_W-1];
  assign out_side  = side_q[QUOT_W-1];

endmodule

// ----- hdl/lav_unit.sv -----
// Vector normalization pipeline: scale, sum of squares, root and divide to Q2.30.
module lav_unit #(
  parameter int IN_W   = 33,
  parameter int SIDE_W = 1
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             en,
  input  logic                                             in_valid,
  input  logic [lav_pkg::AXES-1:0][IN_W-1:0]               vec,
  input  logic [SIDE_W-1:0]                                in_side,
  output logic                                             out_valid,
  output logic [lav_pkg::AXES-1:0][lav_pkg::FIELD_W-1:0]   axis,
  output logic                                             zero,
  output logic [SIDE_W-1:0]                                out_side
);
  import lav_pkg::*;

  localparam int POS_W = $clog2(IN_W);
  localparam logic [POS_W-1:0] TOP_POS = POS_W'(NORM_W - 1);
  localparam int SQ_SIDE_W = AXES * NORM_W + AXES + 1 + SIDE_W;
  localparam int DV_SIDE_W = AXES + 1 + SIDE_W;

  logic v0, v1, v2, v3, v4, v5, v6, v7;
  logic [AXES-1:0][IN_W-1:0] mag0, mag1, mag2;
  logic [AXES-1:0] neg0, neg1, neg2, neg3, neg4, neg5;
  logic [IN_W-1:0] max1;
  logic [POS_W-1:0] pos2;
  logic zero2, zero3, zero4, zero5;
  logic [AXES-1:0][NORM_W-1:0] a3, a4, a5;
  logic [AXES-1:0][2*NORM_W-1:0] sq4;
  logic [WIDE_W-1:0] sum5;
  logic [SIDE_W-1:0] side0, side1, side2, side3, side4, side5;

  logic [IN_W-1:0] max01;
  logic [POS_W-1:0] pos_c;
  logic [AXES-1:0][IN_W-1:0] shifted;

  logic sq_vld;
  logic [ROOT_W-1:0] sq_root;
  logic [AXES-1:0][NORM_W-1:0] sq_a;
  logic [AXES-1:0] sq_neg;
  logic sq_zero;
  logic [SIDE_W-1:0] sq_side;

  logic [AXES-1:0][WIDE_W-1:0] num6;
  logic [ROOT_W-1:0] den6;
  logic [AXES-1:0] neg6;
  logic zero6;
  logic [SIDE_W-1:0] side6;

  logic dv_vld;
  logic [AXES-1:0][QUOT_W-1:0] dv_quot;
  logic [AXES-1:0] dv_neg;
  logic dv_zero;
  logic [SIDE_W-1:0] dv_side;

  assign max01 = (mag0[0] > mag0[1]) ? mag0[0] : mag0[1];

  always_comb begin
    pos_c = '0;
    for (int i = 0; i < IN_W; i++) begin
      if (max1[i]) pos_c = POS_W'(i);
    end
  end

  // Bring the largest magnitude to bit NORM_W-1; a right shift truncates.
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      if (pos2 > TOP_POS) shifted[a] = mag2[a] >> (pos2 - TOP_POS);
      else                shifted[a] = mag2[a] << (TOP_POS - pos2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      {v0, v1, v2, v3, v4, v5, v6, v7} <= '0;
    end else if (en) begin
      {v0, v1, v2, v3, v4, v5, v6, v7} <= {in_valid, v0, v1, v2, v3, v4, sq_vld, dv_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < AXES; a++) begin
        neg0[a] <= vec[a][IN_W-1];
        mag0[a] <= vec[a][IN_W-1] ? (IN_W'(0) - vec[a]) : vec[a];
      end
      side0 <= in_side;

      mag1  <= mag0;
      neg1  <= neg0;
      max1  <= (max01 > mag0[2]) ? max01 : mag0[2];
      side1 <= side0;

      mag2  <= mag1;
      neg2  <= neg1;
      pos2  <= pos_c;
      zero2 <= (max1 == '0);
      side2 <= side1;

      for (int a = 0; a < AXES; a++) a3[a] <= shifted[a][NORM_W-1:0];
      neg3  <= neg2;
      zero3 <= zero2;
      side3 <= side2;

      for (int a = 0; a < AXES; a++) sq4[a] <= a3[a] * a3[a];
      a4    <= a3;
      neg4  <= neg3;
      zero4 <= zero3;
      side4 <= side3;

      sum5  <= WIDE_W'(sq4[0]) + WIDE_W'(sq4[1]) + WIDE_W'(sq4[2]);
      a5    <= a4;
      neg5  <= neg4;
      zero5 <= zero4;
      side5 <= side4;

      for (int a = 0; a < AXES; a++) begin
        num6[a] <= (WIDE_W'(sq_a[a]) << FRAC_W) + WIDE_W'(sq_root >> 1);
      end
      den6  <= sq_root;
      neg6  <= sq_neg;
      zero6 <= sq_zero;
      side6 <= sq_side;

      for (int a = 0; a < AXES; a++) begin
        if (dv_zero)        axis[a] <= '0;
        else if (dv_neg[a]) axis[a] <= FIELD_W'(0) - FIELD_W'(dv_quot[a]);
        else                axis[a] <= FIELD_W'(dv_quot[a]);
      end
      zero     <= dv_zero;
      out_side <= dv_side;
    end
  end

  lav_sqrt #(.SIDE_W(SQ_SIDE_W)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v5),
    .n         (sum5),
    .in_side   ({a5, neg5, zero5, side5}),
    .out_valid (sq_vld),
    .root      (sq_root),
    .out_side  ({sq_a, sq_neg, sq_zero, sq_side})
  );

  lav_div #(.SIDE_W(DV_SIDE_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v6),
    .num       (num6),
    .den       (den6),
    .in_side   ({neg6, zero6, side6}),
    .out_valid (dv_vld),
    .quot      (dv_quot),
    .out_side  ({dv_neg, dv_zero, dv_side})
  );

  assign out_valid = v7;

endmodule
